@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the point cloud block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dpc_pkg.sv @@
// Shared types and constants for the depth to point cloud block.
// No dependencies; imported by every module of the block.
package dpc_pkg;

  // Geometry and number formats
  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = 12;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 13;
  localparam int DEPTH_W    = 16;
  localparam int COORD_W    = 16;
  localparam int IFOC_W     = 24;
  localparam int PROD1_W    = 32;
  localparam int PROD2_W    = 56;
  localparam int POS_W      = 32;
  localparam int COLOR_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [COLOR_W-1:0] GREY_LEVEL = 8'd122;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_PRINCIPAL_X     = 3'd1,
    REG_PRINCIPAL_Y     = 3'd2,
    REG_INVERSE_FOCAL_X = 3'd3,
    REG_INVERSE_FOCAL_Y = 3'd4,
    REG_DEPTH_MIN       = 3'd5,
    REG_DEPTH_MAX       = 3'd6,
    REG_USE_COLOUR      = 3'd7
  } cfg_reg_t;

  // Register file contents as seen by the datapath (width already clamped)
  typedef struct packed {
    logic [WIDTH_W-1:0] width_eff;
    logic [COORD_W-1:0] principal_x;
    logic [COORD_W-1:0] principal_y;
    logic [IFOC_W-1:0]  inverse_focal_x;
    logic [IFOC_W-1:0]  inverse_focal_y;
    logic [DEPTH_W-1:0] depth_min;
    logic [DEPTH_W-1:0] depth_max;
    logic               use_colour;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // input request accepted this cycle
    logic mul1_en;   // first product stage
    logic mul2_en;   // second product stage
    logic out_load;  // round, saturate and load output register
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic emit_hit;  // pixel at the input lands on an even row and column
  } dp_status_t;

endpackage

@@ hw/rtl/dpc_cfg_regs.sv @@
// Configuration register file of the depth to point cloud block.
// Depends on dpc_pkg.
module dpc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dpc_pkg::cfg_t                   cfg
);
  import dpc_pkg::*;

  logic [WIDTH_W-1:0] image_width_r;
  logic [COORD_W-1:0] principal_x_r;
  logic [COORD_W-1:0] principal_y_r;
  logic [IFOC_W-1:0]  inverse_focal_x_r;
  logic [IFOC_W-1:0]  inverse_focal_y_r;
  logic [DEPTH_W-1:0] depth_min_r;
  logic [DEPTH_W-1:0] depth_max_r;
  logic               use_colour_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= WIDTH_W'(640);
      principal_x_r     <= COORD_W'(5120);
      principal_y_r     <= COORD_W'(3840);
      inverse_focal_x_r <= IFOC_W'(31457);
      inverse_focal_y_r <= IFOC_W'(31457);
      depth_min_r       <= DEPTH_W'(100);
      depth_max_r       <= DEPTH_W'(8000);
      use_colour_r      <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:     image_width_r     <= cfg_data[WIDTH_W-1:0];
        REG_PRINCIPAL_X:     principal_x_r     <= cfg_data[COORD_W-1:0];
        REG_PRINCIPAL_Y:     principal_y_r     <= cfg_data[COORD_W-1:0];
        REG_INVERSE_FOCAL_X: inverse_focal_x_r <= cfg_data[IFOC_W-1:0];
        REG_INVERSE_FOCAL_Y: inverse_focal_y_r <= cfg_data[IFOC_W-1:0];
        REG_DEPTH_MIN:       depth_min_r       <= cfg_data[DEPTH_W-1:0];
        REG_DEPTH_MAX:       depth_max_r       <= cfg_data[DEPTH_W-1:0];
        REG_USE_COLOUR:      use_colour_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the row width into 2..MAX_WIDTH
  always_comb begin
    if (image_width_r < WIDTH_W'(2)) begin
      cfg.width_eff = WIDTH_W'(2);
    end else if (image_width_r > WIDTH_W'(MAX_WIDTH)) begin
      cfg.width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      cfg.width_eff = image_width_r;
    end
    cfg.principal_x     = principal_x_r;
    cfg.principal_y     = principal_y_r;
    cfg.inverse_focal_x = inverse_focal_x_r;
    cfg.inverse_focal_y = inverse_focal_y_r;
    cfg.depth_min       = depth_min_r;
    cfg.depth_max       = depth_max_r;
    cfg.use_colour      = use_colour_r;
  end

endmodule

@@ hw/rtl/dpc_ctrl.sv @@
// Sequencing controller: accept, two multiply steps, output load.
// Depends on dpc_pkg.
module dpc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  dpc_pkg::dp_status_t   status,
  output dpc_pkg::ctrl_cmd_t    cmd
);
  import dpc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Commands and next state
  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.mul1_en  = 1'b0;
    cmd.mul2_en  = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = accept;
        if (accept && status.emit_hit) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1_en = 1'b1;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2_en = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // wait here until the output register can take the result
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);
  end

  // State and registered output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/dpc_dpath.sv @@
// Datapath: raster counters, offset magnitudes, two-step products per axis,
// rounding and saturation into the output register. Depends on dpc_pkg.
module dpc_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dpc_pkg::cfg_t                 cfg,
  input  dpc_pkg::ctrl_cmd_t            cmd,
  output dpc_pkg::dp_status_t           status,
  input  logic                          in_frame_start,
  input  logic [dpc_pkg::DEPTH_W-1:0]   in_depth_mm,
  input  logic [dpc_pkg::COLOR_W-1:0]   in_red,
  input  logic [dpc_pkg::COLOR_W-1:0]   in_green,
  input  logic [dpc_pkg::COLOR_W-1:0]   in_blue,
  output logic                          out_vertex_valid,
  output logic signed [dpc_pkg::POS_W-1:0] out_pos_x,
  output logic signed [dpc_pkg::POS_W-1:0] out_pos_y,
  output logic [dpc_pkg::DEPTH_W-1:0]   out_pos_z,
  output logic [dpc_pkg::COLOR_W-1:0]   out_red,
  output logic [dpc_pkg::COLOR_W-1:0]   out_green,
  output logic [dpc_pkg::COLOR_W-1:0]   out_blue
);
  import dpc_pkg::*;

  // Round to nearest (ties away from zero) and saturate to signed 32 bits
  function automatic logic [POS_W-1:0] round_sat(input logic [PROD2_W-1:0] prod,
                                                 input logic neg);
    logic [PROD2_W:0]  sum;
    logic [POS_W:0]    mag;
    logic [POS_W-1:0]  res;
    sum = {1'b0, prod} + (PROD2_W+1)'(57'h0800000);
    mag = sum[PROD2_W:24];
    if (neg) begin
      if (mag > 33'h080000000) begin
        mag = 33'h080000000;
      end
      res = POS_W'(~mag + 33'd1);
    end else if (mag > 33'h07FFFFFFF) begin
      res = 32'h7FFFFFFF;
    end else begin
      res = mag[POS_W-1:0];
    end
    return res;
  endfunction

  // Raster position
  logic [COL_W-1:0]   col_r, col_nxt, cur_col;
  logic [ROW_W-1:0]   row_r, row_nxt, cur_row;
  logic [WIDTH_W-1:0] col_inc;

  // Captured item
  logic               valid_r;
  logic               neg_x_r, neg_y_r;
  logic [COORD_W-1:0] mag_x_r, mag_y_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [COLOR_W-1:0] red_r, green_r, blue_r;

  // Product stages
  logic [PROD1_W-1:0] p1x_r, p1y_r;
  logic [PROD2_W-1:0] p2x_r, p2y_r;

  // Output register
  logic               vv_r;
  logic [POS_W-1:0]   pos_x_r, pos_y_r;
  logic [DEPTH_W-1:0] pos_z_r;
  logic [COLOR_W-1:0] ored_r, ogreen_r, oblue_r;

  // Capture-cycle combinational values
  logic               depth_ok;
  logic [COORD_W-1:0] scaled_x, scaled_y;
  logic               neg_x, neg_y;
  logic [COORD_W-1:0] mag_x, mag_y;

  // Counters restart on the first pixel of a frame
  always_comb begin
    cur_col = in_frame_start ? '0 : col_r;
    cur_row = in_frame_start ? '0 : row_r;
    col_inc = {1'b0, cur_col} + WIDTH_W'(1);
    if (col_inc >= cfg.width_eff) begin
      col_nxt = '0;
      row_nxt = cur_row + ROW_W'(1);
    end else begin
      col_nxt = col_inc[COL_W-1:0];
      row_nxt = cur_row;
    end
    status.emit_hit = !cur_col[0] && !cur_row[0];
  end

  // Offsets from the principal point in 1/16 pixel
  always_comb begin
    depth_ok = (in_depth_mm >= cfg.depth_min) && (in_depth_mm <= cfg.depth_max);
    scaled_x = {cur_col, 4'b0000};
    scaled_y = {cur_row, 4'b0000};
    neg_x    = scaled_x < cfg.principal_x;
    neg_y    = scaled_y < cfg.principal_y;
    mag_x    = neg_x ? cfg.principal_x - scaled_x : scaled_x - cfg.principal_x;
    mag_y    = neg_y ? cfg.principal_y - scaled_y : scaled_y - cfg.principal_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.capture) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Item capture; an invalid depth zeroes the magnitudes so products are zero
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      valid_r <= depth_ok;
      neg_x_r <= neg_x;
      neg_y_r <= neg_y;
      mag_x_r <= depth_ok ? mag_x : '0;
      mag_y_r <= depth_ok ? mag_y : '0;
      depth_r <= depth_ok ? in_depth_mm : '0;
      if (!depth_ok) begin
        red_r   <= '0;
        green_r <= '0;
        blue_r  <= '0;
      end else if (cfg.use_colour) begin
        red_r   <= in_red;
        green_r <= in_green;
        blue_r  <= in_blue;
      end else begin
        red_r   <= GREY_LEVEL;
        green_r <= GREY_LEVEL;
        blue_r  <= GREY_LEVEL;
      end
    end
  end

  // Offset times depth
  always_ff @(posedge clk) begin
    if (cmd.mul1_en) begin
      p1x_r <= PROD1_W'(mag_x_r) * PROD1_W'(depth_r);
      p1y_r <= PROD1_W'(mag_y_r) * PROD1_W'(depth_r);
    end
  end

  // Times inverse focal length, Q0.24
  always_ff @(posedge clk) begin
    if (cmd.mul2_en) begin
      p2x_r <= PROD2_W'(p1x_r) * PROD2_W'(cfg.inverse_focal_x);
      p2y_r <= PROD2_W'(p1y_r) * PROD2_W'(cfg.inverse_focal_y);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      vv_r     <= valid_r;
      pos_x_r  <= round_sat(p2x_r, neg_x_r);
      pos_y_r  <= round_sat(p2y_r, neg_y_r);
      pos_z_r  <= depth_r;
      ored_r   <= red_r;
      ogreen_r <= green_r;
      oblue_r  <= blue_r;
    end
  end

  assign out_vertex_valid = vv_r;
  assign out_pos_x        = pos_x_r;
  assign out_pos_y        = pos_y_r;
  assign out_pos_z        = pos_z_r;
  assign out_red          = ored_r;
  assign out_green        = ogreen_r;
  assign out_blue         = oblue_r;

endmodule

@@ hw/rtl/depth_to_point_cloud_top.sv @@
// Top level of the depth to point cloud block.
// Depends on dpc_pkg, dpc_cfg_regs, dpc_ctrl, dpc_dpath and assert_macros.svh.
//
// Back-projects a row-major depth raster (one pixel per request, with colour)
// into vertices through a pinhole model. Only pixels on even rows and even
// columns produce a vertex; in_frame_start restarts the raster. A pixel that
// yields no vertex leaves the input free. A pixel that yields a vertex is
// captured, then stalls the input through the offset-times-depth multiply
// and the times inverse focal length multiply (a two-step chain per axis),
// then through round/saturate into the output register. The last step waits
// while a previous vertex is still stalled in the output register. Write
// configuration only while the block is idle.
`include "assert_macros.svh"

module depth_to_point_cloud_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // pixel requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_frame_start,
  input  logic [dpc_pkg::DEPTH_W-1:0]       in_depth_mm,
  input  logic [dpc_pkg::COLOR_W-1:0]       in_red,
  input  logic [dpc_pkg::COLOR_W-1:0]       in_green,
  input  logic [dpc_pkg::COLOR_W-1:0]       in_blue,
  // vertex requests
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_vertex_valid,
  output logic signed [dpc_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [dpc_pkg::POS_W-1:0]  out_pos_y,
  output logic [dpc_pkg::DEPTH_W-1:0]       out_pos_z,
  output logic [dpc_pkg::COLOR_W-1:0]       out_red,
  output logic [dpc_pkg::COLOR_W-1:0]       out_green,
  output logic [dpc_pkg::COLOR_W-1:0]       out_blue
);
  import dpc_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  dpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  dpc_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_frame_start   (in_frame_start),
    .in_depth_mm      (in_depth_mm),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_vertex_valid (out_vertex_valid),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_pos_z        (out_pos_z),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue)
  );

  // Checks
  `ASSERT_NEXT(a_skip_no_stall, clk, rst_n, cmd.capture && !status.emit_hit, !in_stall, "non-emitting pixel stalled the input")
  `ASSERT_NEXT(a_emit_stalls, clk, rst_n, cmd.capture && status.emit_hit, in_stall, "emitting pixel did not start the multiply sequence")
  `ASSERT_IMPL(a_invalid_zero, clk, rst_n, out_valid && !out_vertex_valid, out_pos_x == 0 && out_pos_y == 0 && out_pos_z == 0, "invalid vertex with nonzero coordinates")
  `ASSERT_IMPL(a_load_when_free, clk, rst_n, cmd.out_load, !out_valid || !out_stall, "output register overwritten while stalled")

endmodule

@@ tb/depth_to_point_cloud_top_test.sv @@
// Self-checking testbench for depth_to_point_cloud_top: directed table, random phases, edge runs.
// A local back-projection predictor checks each vertex. Depends on dpc_pkg and the block RTL.
module depth_to_point_cloud_top_test;
  import dpc_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_CAP     = 40;

  // Expected vertex, laid out at the block's field widths
  typedef struct packed {
    logic                     vertex_valid;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [DEPTH_W-1:0]       pos_z;
    logic [COLOR_W-1:0]       red;
    logic [COLOR_W-1:0]       green;
    logic [COLOR_W-1:0]       blue;
  } vertex_t;

  // Local copy of the camera registers
  typedef struct packed {
    logic [WIDTH_W-1:0] image_width;
    logic [COORD_W-1:0] principal_x;
    logic [COORD_W-1:0] principal_y;
    logic [IFOC_W-1:0]  inverse_focal_x;
    logic [IFOC_W-1:0]  inverse_focal_y;
    logic [DEPTH_W-1:0] depth_min;
    logic [DEPTH_W-1:0] depth_max;
    logic               use_colour;
  } camera_cfg_t;

  localparam camera_cfg_t CAM_RESET = '{13'd640, 16'd5120, 16'd3840, 24'd31457, 24'd31457,
                                         16'd100, 16'd8000, 1'b1};

  // Directed table: pixel requests and register writes, in order
  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 frame_start;
    logic [DEPTH_W-1:0]   depth;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 zero_vertex;  // vertex, if any, is all zero
    cfg_reg_t             reg_index;
    logic [CFG_DATA_W-1:0] value;
  } stim_row_t;

  function automatic stim_row_t px(logic fs, logic [15:0] d, logic [7:0] r, logic [7:0] g,
                                   logic [7:0] b, logic zero_vertex);
    return '{ROW_PIXEL, fs, d, r, g, b, zero_vertex, REG_IMAGE_WIDTH, 24'd0};
  endfunction

  function automatic stim_row_t wr(cfg_reg_t idx, logic [23:0] val);
    return '{ROW_WRITE, 1'b0, 16'd0, 8'd0, 8'd0, 8'd0, 1'b0, idx, val};
  endfunction

  localparam int DIRECTED_ROWS = 24;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    px(1'b1, 16'd100,   8'd0,   8'd0,   8'd0,   1'b0),   // first pixel after reset, window floor
    px(1'b0, 16'd5000,  8'd1,   8'd2,   8'd4,   1'b0),
    px(1'b0, 16'd99,    8'd8,   8'd16,  8'd32,  1'b1),   // just below window
    px(1'b0, 16'd65535, 8'd64,  8'd128, 8'd255, 1'b0),
    px(1'b0, 16'd8000,  8'd255, 8'd255, 8'd255, 1'b0),   // window ceiling
    px(1'b0, 16'd0,     8'd0,   8'd0,   8'd0,   1'b0),
    px(1'b0, 16'd8001,  8'd9,   8'd9,   8'd9,   1'b1),   // just above window
    px(1'b0, 16'd0,     8'd7,   8'd7,   8'd7,   1'b0),
    px(1'b0, 16'd0,     8'd200, 8'd100, 8'd50,  1'b1),   // zero depth
    wr(REG_USE_COLOUR, 24'd0),
    px(1'b1, 16'd1234,  8'd170, 8'd85,  8'd15,  1'b0),   // grey output
    wr(REG_INVERSE_FOCAL_X, 24'hFFFFFF),
    wr(REG_PRINCIPAL_X, 24'h00FFFF),
    wr(REG_DEPTH_MAX, 24'h00FFFF),
    px(1'b0, 16'd65535, 8'd1,   8'd1,   8'd1,   1'b0),
    px(1'b0, 16'd65535, 8'd254, 8'd254, 8'd254, 1'b0),   // x saturates negative
    wr(REG_DEPTH_MIN, 24'h00FFFF),
    px(1'b1, 16'd65534, 8'd3,   8'd3,   8'd3,   1'b1),
    px(1'b0, 16'd65535, 8'd0,   8'd0,   8'd0,   1'b0),
    px(1'b0, 16'd65535, 8'd128, 8'd64,  8'd32,  1'b0),   // one-value window
    wr(REG_DEPTH_MAX, 24'd0),
    px(1'b1, 16'd65535, 8'd5,   8'd6,   8'd7,   1'b1),   // empty window
    wr(REG_IMAGE_WIDTH, 24'd0),
    px(1'b1, 16'd100,   8'd11,  8'd22,  8'd33,  1'b1)
  };

  // Block ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_frame_start = 1'b0;
  logic [DEPTH_W-1:0]    in_depth_mm = '0;
  logic [COLOR_W-1:0]    in_red = '0;
  logic [COLOR_W-1:0]    in_green = '0;
  logic [COLOR_W-1:0]    in_blue = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_vertex_valid;
  logic signed [POS_W-1:0] out_pos_x;
  logic signed [POS_W-1:0] out_pos_y;
  logic [DEPTH_W-1:0]    out_pos_z;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_blue;

  // Predictor state and scoreboard
  camera_cfg_t cam = CAM_RESET;
  int          raster_col = 0;
  int          raster_row = 0;
  vertex_t     pending_vertices[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          steady = 1'b0;  // no idling on either side while set

  depth_to_point_cloud_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_frame_start(in_frame_start),
    .in_depth_mm(in_depth_mm), .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall), .out_vertex_valid(out_vertex_valid),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(string msg);
    if (mismatch_count < PRINT_CAP)
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // One axis: offset in 1/16 pixel times depth times 1/f, rounded half away, saturated
  function automatic logic signed [POS_W-1:0] project_coord(input logic [11:0] idx,
      input logic [15:0] centre, input logic [15:0] depth, input logic [23:0] inv_focal);
    logic [15:0] scaled;
    logic        neg;
    logic [15:0] mag;
    logic [63:0] prod;
    logic [63:0] rounded;
    scaled  = {idx, 4'b0000};
    neg     = scaled < centre;
    mag     = neg ? centre - scaled : scaled - centre;
    prod    = 64'(mag) * 64'(depth) * 64'(inv_focal);
    rounded = (prod + 64'h80_0000) >> 24;
    if (neg) begin
      if (rounded > 64'h8000_0000) rounded = 64'h8000_0000;
      return -rounded[31:0];
    end
    if (rounded > 64'h7FFF_FFFF) rounded = 64'h7FFF_FFFF;
    return rounded[31:0];
  endfunction

  // Advance the raster by one pixel; returns 1 when the pixel yields a vertex
  function automatic logic back_project(input logic fs, input logic [15:0] depth,
      input logic [7:0] r, input logic [7:0] g, input logic [7:0] b, output vertex_t v);
    int   width;
    logic emit;
    width = int'(cam.image_width);
    if (width < 2) width = 2;
    if (width > MAX_WIDTH) width = MAX_WIDTH;
    if (fs) begin
      raster_col = 0;
      raster_row = 0;
    end
    emit = (raster_col % 2 == 0) && (raster_row % 2 == 0);
    v = '0;
    if (emit && depth >= cam.depth_min && depth <= cam.depth_max) begin
      v.vertex_valid = 1'b1;
      v.pos_x = project_coord(12'(raster_col), cam.principal_x, depth, cam.inverse_focal_x);
      v.pos_y = project_coord(12'(raster_row), cam.principal_y, depth, cam.inverse_focal_y);
      v.pos_z = depth;
      v.red   = cam.use_colour ? r : GREY_LEVEL;
      v.green = cam.use_colour ? g : GREY_LEVEL;
      v.blue  = cam.use_colour ? b : GREY_LEVEL;
    end
    raster_col++;
    if (raster_col >= width) begin
      raster_col = 0;
      raster_row = (raster_row + 1) % 4096;
    end
    return emit;
  endfunction

  // Vertex side: compare accepted vertices, then stall at random
  task automatic check_vertex();
    vertex_t want;
    if (pending_vertices.size() == 0) begin
      flag_mismatch("vertex arrived with none pending");
      return;
    end
    want = pending_vertices.pop_front();
    if (out_vertex_valid !== want.vertex_valid)
      flag_mismatch($sformatf("vertex_valid %0b want %0b", out_vertex_valid, want.vertex_valid));
    if (out_pos_x !== want.pos_x)
      flag_mismatch($sformatf("pos_x %0d want %0d", out_pos_x, want.pos_x));
    if (out_pos_y !== want.pos_y)
      flag_mismatch($sformatf("pos_y %0d want %0d", out_pos_y, want.pos_y));
    if (out_pos_z !== want.pos_z)
      flag_mismatch($sformatf("pos_z %0d want %0d", out_pos_z, want.pos_z));
    if (out_red !== want.red)
      flag_mismatch($sformatf("red %0d want %0d", out_red, want.red));
    if (out_green !== want.green)
      flag_mismatch($sformatf("green %0d want %0d", out_green, want.green));
    if (out_blue !== want.blue)
      flag_mismatch($sformatf("blue %0d want %0d", out_blue, want.blue));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_vertex();
    out_stall <= !steady && ($urandom_range(99) < 24);
  end

  // Pixel side: optional gap, hold the request until taken, then predict
  task automatic send_pixel(logic fs, logic [15:0] depth, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic zero_vertex);
    vertex_t v;
    while (!steady && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_frame_start <= fs;
    in_depth_mm    <= depth;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    do @(posedge clk); while (in_stall);
    if (back_project(fs, depth, r, g, b, v)) begin
      if (zero_vertex) v = '0;
      pending_vertices.insert(pending_vertices.size(), v);
    end
  endtask

  // Drop valid, wait for every pending vertex, then let a pixel in flight finish
  task automatic settle_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_vertices.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:     cam.image_width     = val[WIDTH_W-1:0];
      REG_PRINCIPAL_X:     cam.principal_x     = val[COORD_W-1:0];
      REG_PRINCIPAL_Y:     cam.principal_y     = val[COORD_W-1:0];
      REG_INVERSE_FOCAL_X: cam.inverse_focal_x = val[IFOC_W-1:0];
      REG_INVERSE_FOCAL_Y: cam.inverse_focal_y = val[IFOC_W-1:0];
      REG_DEPTH_MIN:       cam.depth_min       = val[DEPTH_W-1:0];
      REG_DEPTH_MAX:       cam.depth_max       = val[DEPTH_W-1:0];
      REG_USE_COLOUR:      cam.use_colour      = val[0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_centre();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom());
      default: return 16'($urandom_range(1200));
    endcase
  endfunction

  function automatic logic [23:0] pick_inv_focal();
    case ($urandom_range(4))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom());
      default: return 24'($urandom_range(60000, 10000));
    endcase
  endfunction

  // New camera setting for a phase; widths mostly small so rows advance
  task automatic pick_camera();
    logic [CFG_DATA_W-1:0] width, lo, hi;
    case ($urandom_range(7))
      0: width = 24'($urandom_range(1));
      1: width = 24'd2;
      2: width = 24'($urandom_range(64, 17));
      3: case ($urandom_range(2))
           0: width = 24'd4096;
           1: width = 24'd4097;
           default: width = 24'd8191;
         endcase
      default: width = 24'($urandom_range(16, 3));
    endcase
    case ($urandom_range(5))
      0: begin lo = 24'd0; hi = 24'hFFFF; end
      1: begin lo = 24'($urandom_range(65535, 30000)); hi = 24'($urandom_range(20000)); end
      2: begin lo = 24'($urandom()) & 24'hFFFF; hi = 24'hFFFF; end
      default: begin
        lo = 24'($urandom_range(2000));
        hi = 24'($urandom_range(65535, 3000));
      end
    endcase
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_PRINCIPAL_X, 24'(pick_centre()));
    write_reg(REG_PRINCIPAL_Y, 24'(pick_centre()));
    write_reg(REG_INVERSE_FOCAL_X, pick_inv_focal());
    write_reg(REG_INVERSE_FOCAL_Y, pick_inv_focal());
    write_reg(REG_DEPTH_MIN, lo);
    write_reg(REG_DEPTH_MAX, hi);
    write_reg(REG_USE_COLOUR, 24'($urandom_range(1)));
  endtask

  // Depth mostly inside the window, with edges and full-range noise
  task automatic send_random_pixel(logic fs);
    logic [15:0] d;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6 && cam.depth_min <= cam.depth_max)
      d = 16'($urandom_range(cam.depth_max, cam.depth_min));
    else if (pick == 6) begin
      case ($urandom_range(5))
        0: d = 16'd0;
        1: d = 16'hFFFF;
        2: d = cam.depth_min;
        3: d = cam.depth_max;
        4: d = cam.depth_min - 16'd1;
        default: d = cam.depth_max + 16'd1;
      endcase
    end else
      d = 16'($urandom());
    send_pixel(fs, d, 8'($urandom()), 8'($urandom()), 8'($urandom()), 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table from the reset setting
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE)
        write_reg(DIRECTED[i].reg_index, DIRECTED[i].value);
      else
        send_pixel(DIRECTED[i].frame_start, DIRECTED[i].depth, DIRECTED[i].red,
                   DIRECTED[i].green, DIRECTED[i].blue, DIRECTED[i].zero_vertex);
    end

    // Random phases, each under a fresh camera setting; phase 1 runs without idling
    for (int phase = 0; phase < 6; phase++) begin
      pick_camera();
      steady = (phase == 1);
      for (int i = 0; i < 130; i++) begin
        if ($urandom_range(129) == 0) settle_block();
        if (i == 0) send_random_pixel($urandom_range(3) != 0);
        else send_random_pixel($urandom_range(63) == 0);
      end
      steady = 1'b0;
    end

    // Width shrinks mid-row while the column is already past it
    pick_camera();
    write_reg(REG_IMAGE_WIDTH, 24'd8191);
    for (int i = 0; i < 250; i++) send_random_pixel(i == 0);
    write_reg(REG_IMAGE_WIDTH, 24'd100);
    for (int i = 0; i < 100; i++) send_random_pixel(1'b0);

    // Two-pixel rows from a far principal column; x saturates negative
    write_reg(REG_IMAGE_WIDTH, 24'd1);
    write_reg(REG_PRINCIPAL_X, 24'hFFFF);
    write_reg(REG_PRINCIPAL_Y, 24'd0);
    write_reg(REG_INVERSE_FOCAL_X, 24'hFFFFFF);
    write_reg(REG_INVERSE_FOCAL_Y, 24'hFFFFFF);
    write_reg(REG_DEPTH_MIN, 24'd0);
    write_reg(REG_DEPTH_MAX, 24'hFFFF);
    write_reg(REG_USE_COLOUR, 24'($urandom_range(1)));
    for (int i = 0; i < 200; i++) begin
      if ($urandom_range(7) == 0)
        send_random_pixel(i == 0);
      else
        send_pixel(i == 0, 16'($urandom_range(65535, 30000)), 8'($urandom()),
                   8'($urandom()), 8'($urandom()), 1'b0);
    end

    settle_block();
    if (pending_vertices.size() != 0)
      flag_mismatch($sformatf("%0d vertices never arrived", pending_vertices.size()));
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
